@@ rtl/lge_pkg.sv @@
`default_nettype none

package lge_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);

  // Width of the row and column fields of an input item.
  localparam int FLD_W     = 6;
  // Wide enough to compare a field with a grid size of up to 256.
  localparam int CMP_W     = 9;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ACT_TOGGLE = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_STEP   = 2'd2;

  localparam logic signed [4:0] CNT_BORDER = -5'sd1;
  localparam logic [3:0]        LIFE_BIRTH = 4'd3;
  localparam logic [3:0]        LIFE_KEEP  = 4'd2;

  typedef enum logic [1:0] {
    OP_TOGGLE,
    OP_READ,
    OP_STEP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             on_grid;
    logic             border;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } entry_t;

  typedef logic [GRID_COLS-1:0] row_t;

  function automatic logic [ROW_W-1:0] row_idx(input logic [FLD_W-1:0] r);
    logic [ROW_W+FLD_W-1:0] ext;
    ext = {{ROW_W{1'b0}}, r};
    return ext[ROW_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] col_idx(input logic [FLD_W-1:0] c);
    logic [COL_W+FLD_W-1:0] ext;
    ext = {{COL_W{1'b0}}, c};
    return ext[COL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lge_if.sv @@
`default_nettype none

interface lge_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [lge_pkg::FLD_W-1:0] row;
  logic [lge_pkg::FLD_W-1:0] col;

  modport source (output valid, output action, output row, output col, input ready);
  modport sink   (input valid, input action, input row, input col, output ready);
endinterface

interface lge_out_if;
  logic              valid;
  logic              ready;
  logic              cell_alive;
  logic signed [4:0] neighbor_count;

  modport source (output valid, output cell_alive, output neighbor_count, input ready);
  modport sink   (input valid, input cell_alive, input neighbor_count, output ready);
endinterface

`default_nettype wire

@@ rtl/lge_front.sv @@
`default_nettype none

module lge_front (
  lge_in_if.sink          item_i,
  input  logic            full_i,
  output logic            push_o,
  output lge_pkg::entry_t entry_o
);

  logic                      on_grid;
  logic [lge_pkg::ROW_W-1:0] row;
  logic [lge_pkg::COL_W-1:0] col;

  always_comb begin
    on_grid = (lge_pkg::CMP_W'(item_i.row) < lge_pkg::CMP_W'(lge_pkg::GRID_ROWS)) &&
              (lge_pkg::CMP_W'(item_i.col) < lge_pkg::CMP_W'(lge_pkg::GRID_COLS));
    row = on_grid ? lge_pkg::row_idx(item_i.row) : '0;
    col = on_grid ? lge_pkg::col_idx(item_i.col) : '0;

    entry_o.on_grid = on_grid;
    entry_o.row     = row;
    entry_o.col     = col;
    entry_o.border  = on_grid &&
                      ((row == '0) || (row == lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 1)) ||
                       (col == '0) || (col == lge_pkg::COL_W'(lge_pkg::GRID_COLS - 1)));

    unique case (item_i.action)
      lge_pkg::ACT_TOGGLE: entry_o.op = on_grid ? lge_pkg::OP_TOGGLE : lge_pkg::OP_READ;
      lge_pkg::ACT_STEP:   entry_o.op = lge_pkg::OP_STEP;
      default:             entry_o.op = lge_pkg::OP_READ;
    endcase
  end

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

endmodule

`default_nettype wire

@@ rtl/lge_queue.sv @@
`default_nettype none

module lge_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lge_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            vld_o,
  output lge_pkg::entry_t pop_entry_o
);

  lge_pkg::entry_t               slot_q [lge_pkg::Q_DEPTH];
  logic [lge_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lge_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lge_pkg::Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o      = (cnt_q == lge_pkg::Q_CNT_W'(lge_pkg::Q_DEPTH));
  assign vld_o       = (cnt_q != '0);
  assign pop_entry_o = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lge_pkg::Q_PTR_W'(lge_pkg::Q_DEPTH - 1)) ? '0 :
                 wr_ptr_q + lge_pkg::Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lge_pkg::Q_PTR_W'(lge_pkg::Q_DEPTH - 1)) ? '0 :
                 rd_ptr_q + lge_pkg::Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + lge_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - lge_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lge_back.sv @@
`default_nettype none

module lge_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_vld_i,
  input  lge_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  lge_out_if.source       result_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGL_RD,
    ST_TGL_WR,
    ST_GEN_INIT,
    ST_GEN_PRIME,
    ST_GEN_PRIME2,
    ST_GEN_SWEEP,
    ST_GEN_LAST,
    ST_RES_MID,
    ST_RES_UP,
    ST_RES_DN,
    ST_RES_OUT
  } state_e;

  localparam logic [lge_pkg::ROW_W-1:0] LAST_ROW  = lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 1);
  localparam logic [lge_pkg::ROW_W-1:0] SWEEP_END = lge_pkg::ROW_W'(lge_pkg::GRID_ROWS - 2);

  state_e                    state_q;
  lge_pkg::entry_t           cur_q;
  logic [lge_pkg::ROW_W-1:0] cnt_q;
  lge_pkg::row_t             up_q, mid_q;
  logic                      out_vld_q;
  logic                      out_alive_q;
  logic signed [4:0]         out_cnt_q;

  // Row store: one word per grid row, with a valid bit per row so that rows
  // never written since reset read as dead.
  lge_pkg::row_t             row_mem [lge_pkg::GRID_ROWS];
  logic                      row_vld_q [lge_pkg::GRID_ROWS];
  lge_pkg::row_t             rd_data_q;
  logic                      rd_vld_q;

  logic                      rd_en, wr_en;
  logic [lge_pkg::ROW_W-1:0] rd_addr, wr_addr;
  lge_pkg::row_t             wr_data;
  lge_pkg::row_t             rd_eff;
  lge_pkg::row_t             new_row;
  logic [lge_pkg::ROW_W-1:0] row_up, row_dn;
  logic [lge_pkg::COL_W-1:0] col_lo, col_hi;
  logic [3:0]                cell_cnt;
  logic                      res_alive;
  logic signed [4:0]         res_cnt;
  logic                      out_free;

  function automatic logic [3:0] count8(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

  assign rd_eff   = rd_vld_q ? rd_data_q : '0;
  assign out_free = !out_vld_q || result_o.ready;

  always_comb begin
    logic [3:0] n;
    new_row = '0;
    n       = '0;
    for (int c = 1; c < lge_pkg::GRID_COLS - 1; c++) begin
      n = count8({up_q[c-1], up_q[c], up_q[c+1], mid_q[c-1], mid_q[c+1],
                  rd_eff[c-1], rd_eff[c], rd_eff[c+1]});
      new_row[c] = (n == lge_pkg::LIFE_BIRTH) || (mid_q[c] && (n == lge_pkg::LIFE_KEEP));
    end
  end

  always_comb begin
    row_up    = cur_q.border ? cur_q.row : cur_q.row - lge_pkg::ROW_W'(1);
    row_dn    = cur_q.border ? cur_q.row : cur_q.row + lge_pkg::ROW_W'(1);
    col_lo    = cur_q.border ? cur_q.col : cur_q.col - lge_pkg::COL_W'(1);
    col_hi    = cur_q.border ? cur_q.col : cur_q.col + lge_pkg::COL_W'(1);
    cell_cnt  = count8({up_q[col_lo], up_q[cur_q.col], up_q[col_hi],
                        mid_q[col_lo], mid_q[col_hi],
                        rd_eff[col_lo], rd_eff[cur_q.col], rd_eff[col_hi]});
    res_alive = cur_q.on_grid && mid_q[cur_q.col];
    res_cnt   = (!cur_q.on_grid || cur_q.border) ? lge_pkg::CNT_BORDER :
                $signed({1'b0, cell_cnt});
  end

  always_comb begin
    q_pop_o = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = q_vld_i;
      end
      ST_TGL_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q.row;
      end
      ST_TGL_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_q.row;
        wr_data = rd_eff ^ (lge_pkg::row_t'(1) << cur_q.col);
      end
      ST_GEN_INIT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        wr_en   = 1'b1;
        wr_addr = '0;
      end
      ST_GEN_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = lge_pkg::ROW_W'(1);
      end
      ST_GEN_PRIME2: begin
        rd_en   = 1'b1;
        rd_addr = lge_pkg::ROW_W'(2);
      end
      ST_GEN_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_data = new_row;
        rd_en   = (cnt_q != SWEEP_END);
        rd_addr = cnt_q + lge_pkg::ROW_W'(2);
      end
      ST_GEN_LAST: begin
        wr_en   = 1'b1;
        wr_addr = LAST_ROW;
      end
      ST_RES_MID: begin
        rd_en   = 1'b1;
        rd_addr = cur_q.row;
      end
      ST_RES_UP: begin
        rd_en   = 1'b1;
        rd_addr = row_up;
      end
      ST_RES_DN: begin
        rd_en   = 1'b1;
        rd_addr = row_dn;
      end
      ST_RES_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_vld_q   <= 1'b0;
      cnt_q       <= '0;
      cur_q       <= '0;
      up_q        <= '0;
      mid_q       <= '0;
      out_alive_q <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      if (result_o.ready && (state_q != ST_RES_OUT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_vld_i) begin
            cur_q <= q_entry_i;
            unique case (q_entry_i.op)
              lge_pkg::OP_TOGGLE: state_q <= ST_TGL_RD;
              lge_pkg::OP_STEP:   state_q <= ST_GEN_INIT;
              default:            state_q <= ST_RES_MID;
            endcase
          end
        end
        ST_TGL_RD:     state_q <= ST_TGL_WR;
        ST_TGL_WR:     state_q <= ST_RES_MID;
        ST_GEN_INIT:   state_q <= ST_GEN_PRIME;
        ST_GEN_PRIME: begin
          up_q    <= rd_eff;
          state_q <= ST_GEN_PRIME2;
        end
        ST_GEN_PRIME2: begin
          mid_q   <= rd_eff;
          cnt_q   <= lge_pkg::ROW_W'(1);
          state_q <= ST_GEN_SWEEP;
        end
        ST_GEN_SWEEP: begin
          up_q  <= mid_q;
          mid_q <= rd_eff;
          cnt_q <= cnt_q + lge_pkg::ROW_W'(1);
          if (cnt_q == SWEEP_END) begin
            state_q <= ST_GEN_LAST;
          end
        end
        ST_GEN_LAST:   state_q <= ST_RES_MID;
        ST_RES_MID:    state_q <= ST_RES_UP;
        ST_RES_UP: begin
          mid_q   <= rd_eff;
          state_q <= ST_RES_DN;
        end
        ST_RES_DN: begin
          up_q    <= rd_eff;
          state_q <= ST_RES_OUT;
        end
        ST_RES_OUT: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_alive_q <= res_alive;
            out_cnt_q   <= res_cnt;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lge_pkg::GRID_ROWS; i++) begin
        row_vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= row_mem[rd_addr];
    end
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.cell_alive     = out_alive_q;
  assign result_o.neighbor_count = out_cnt_q;

endmodule

`default_nettype wire

@@ rtl/life_grid_engine_unit.sv @@
// Channel    Direction  Payload                          Handshake
// item_i     in         action, row, col                 valid / ready
// result_o   out        cell_alive, neighbor_count       valid / ready
//
// Items are classified on entry and wait in a two-entry queue for the engine.
// Reads and toggles fetch the rows they need one at a time through the single
// read port of the grid store. A generation step sweeps one row per cycle.
// After reset every row reads as dead at once; no clearing pass is needed.
// A stalled result holds the engine but the queue keeps taking items until it is full.
`default_nettype none

module life_grid_engine_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  lge_in_if.sink    item_i,
  lge_out_if.source result_o
);

  logic            q_push, q_full, q_pop, q_vld;
  lge_pkg::entry_t push_entry, pop_entry;

  lge_front u_front (
    .item_i  (item_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (push_entry)
  );

  lge_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .vld_o        (q_vld),
    .pop_entry_o  (pop_entry)
  );

  lge_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_vld_i   (q_vld),
    .q_entry_i (pop_entry),
    .q_pop_o   (q_pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

@@ rtl/lge_checker.sv @@
`default_nettype none

module lge_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_alive_i,
  input logic signed [4:0] out_count_i
);

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_alive_i) && $stable(out_count_i))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_count_i == -5'sd1) ||
                    (!out_count_i[4] && (out_count_i <= 5'sd8)))
    else $error("neighbour count out of range");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

endmodule

bind life_grid_engine_unit lge_checker u_lge_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_alive_i (result_o.cell_alive),
  .out_count_i (result_o.neighbor_count)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct {
    logic              alive;
    logic signed [4:0] count;
  } cell_view_t;

  logic clk_i;
  logic rst_ni;

  lge_in_if  item_if ();
  lge_out_if result_if ();

  life_grid_engine_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  logic [lge_pkg::GRID_COLS-1:0] grid_rows [lge_pkg::GRID_ROWS];
  cell_view_t                    cell_views_due [$];
  cell_view_t                    view_seen;
  int                            mismatch_count;
  bit                            idle_on;
  int                            hold_cycles;
  int                            ready_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch: %s", what);
    mismatch_count++;
  endtask

  function automatic int grid_neighbours(input int r, input int c);
    int n;
    int i;
    int j;
    n = 0;
    if (r == 0 || c == 0 || r == lge_pkg::GRID_ROWS - 1 || c == lge_pkg::GRID_COLS - 1) begin
      return int'(lge_pkg::CNT_BORDER);
    end
    for (i = r - 1; i <= r + 1; i++) begin
      for (j = c - 1; j <= c + 1; j++) begin
        if (i != r || j != c) begin
          n += grid_rows[i][j];
        end
      end
    end
    return n;
  endfunction

  task automatic grid_advance();
    logic [lge_pkg::GRID_COLS-1:0] next_rows [lge_pkg::GRID_ROWS];
    int r;
    int c;
    int n;
    for (r = 0; r < lge_pkg::GRID_ROWS; r++) begin
      for (c = 0; c < lge_pkg::GRID_COLS; c++) begin
        n = grid_neighbours(r, c);
        next_rows[r][c] = (n == int'(lge_pkg::LIFE_BIRTH)) ||
                          (grid_rows[r][c] && n == int'(lge_pkg::LIFE_KEEP));
      end
    end
    grid_rows = next_rows;
  endtask

  task automatic grid_apply(input logic [1:0] act, input logic [lge_pkg::FLD_W-1:0] row,
                            input logic [lge_pkg::FLD_W-1:0] col);
    cell_view_t view;
    unique case (act)
      lge_pkg::ACT_TOGGLE: begin
        grid_rows[row][col] = ~grid_rows[row][col];
      end
      lge_pkg::ACT_STEP: begin
        grid_advance();
      end
      default: begin
      end
    endcase
    view.alive = grid_rows[row][col];
    view.count = 5'(grid_neighbours(int'(row), int'(col)));
    cell_views_due.push_back(view);
  endtask

  task automatic send_item(input logic [1:0] act, input int row, input int col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid  <= 1'b1;
    item_if.action <= act;
    item_if.row    <= lge_pkg::FLD_W'(row);
    item_if.col    <= lge_pkg::FLD_W'(col);
    do @(posedge clk_i); while (!item_if.ready);
    grid_apply(act, lge_pkg::FLD_W'(row), lge_pkg::FLD_W'(col));
  endtask

  task automatic wait_results_done();
    int guard;
    guard = 0;
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (cell_views_due.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Corner cells are border cells, so their count is -1 whatever their state.
  task automatic test_corners();
    send_item(lge_pkg::ACT_TOGGLE, 0, 0);
    send_item(lge_pkg::ACT_TOGGLE, 0, lge_pkg::GRID_COLS - 1);
    send_item(lge_pkg::ACT_TOGGLE, lge_pkg::GRID_ROWS - 1, 0);
    send_item(lge_pkg::ACT_TOGGLE, lge_pkg::GRID_ROWS - 1, lge_pkg::GRID_COLS - 1);
    send_item(ACT_SPARE, 0, lge_pkg::GRID_COLS - 1);
    send_item(lge_pkg::ACT_READ, lge_pkg::GRID_ROWS - 1, lge_pkg::GRID_COLS - 1);
    wait_results_done();
  endtask

  task automatic test_blinker();
    send_item(lge_pkg::ACT_TOGGLE, 10, 9);
    send_item(lge_pkg::ACT_TOGGLE, 10, 10);
    send_item(lge_pkg::ACT_TOGGLE, 10, 11);
    send_item(lge_pkg::ACT_READ, 10, 10);
    send_item(lge_pkg::ACT_STEP, 9, 10);
    send_item(lge_pkg::ACT_STEP, 10, 10);
    send_item(lge_pkg::ACT_READ, 11, 10);
    wait_results_done();
  endtask

  // Live border cells count as neighbours of the interior but never survive.
  task automatic test_border_neighbours();
    send_item(lge_pkg::ACT_TOGGLE, 0, 10);
    send_item(lge_pkg::ACT_TOGGLE, 0, 11);
    send_item(lge_pkg::ACT_TOGGLE, 0, 12);
    send_item(lge_pkg::ACT_TOGGLE, 1, 11);
    send_item(lge_pkg::ACT_STEP, 1, 11);
    send_item(lge_pkg::ACT_READ, 0, 11);
    wait_results_done();
  endtask

  task automatic test_result_stall();
    int k;
    hold_cycles = 200;
    for (k = 0; k < 12; k++) begin
      send_item(($urandom_range(0, 1) == 0) ? lge_pkg::ACT_TOGGLE : lge_pkg::ACT_READ,
                $urandom_range(0, lge_pkg::GRID_ROWS - 1),
                $urandom_range(0, lge_pkg::GRID_COLS - 1));
    end
    wait_results_done();
  endtask

  // Most items toggle or read inside a small window so that patterns form and
  // evolve over the steps, which also aim inside it; the rest land anywhere on the grid.
  task automatic test_random_play(input int count);
    int k;
    int pick;
    int base_r;
    int base_c;
    base_r = $urandom_range(0, lge_pkg::GRID_ROWS - 6);
    base_c = $urandom_range(0, lge_pkg::GRID_COLS - 6);
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        base_r = $urandom_range(0, lge_pkg::GRID_ROWS - 6);
        base_c = $urandom_range(0, lge_pkg::GRID_COLS - 6);
      end
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        send_item(lge_pkg::ACT_STEP, base_r + $urandom_range(0, 5),
                  base_c + $urandom_range(0, 5));
      end else if (pick < 60) begin
        send_item(lge_pkg::ACT_TOGGLE, base_r + $urandom_range(0, 5),
                  base_c + $urandom_range(0, 5));
      end else if (pick < 85) begin
        send_item(lge_pkg::ACT_READ, base_r + $urandom_range(0, 5),
                  base_c + $urandom_range(0, 5));
      end else if (pick < 95) begin
        send_item(($urandom_range(0, 1) == 0) ? lge_pkg::ACT_TOGGLE : lge_pkg::ACT_READ,
                  $urandom_range(0, lge_pkg::GRID_ROWS - 1),
                  $urandom_range(0, lge_pkg::GRID_COLS - 1));
      end else begin
        send_item(ACT_SPARE, $urandom_range(0, lge_pkg::GRID_ROWS - 1),
                  $urandom_range(0, lge_pkg::GRID_COLS - 1));
      end
    end
    wait_results_done();
  endtask

  initial begin
    result_if.ready = 1'b0;
    ready_gap       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        result_if.ready <= 1'b0;
        hold_cycles--;
      end else if (ready_gap > 0) begin
        result_if.ready <= 1'b0;
        ready_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        ready_gap = $urandom_range(1, 5) - 1;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (cell_views_due.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        view_seen = cell_views_due.pop_front();
        if (result_if.cell_alive !== view_seen.alive) begin
          report_mismatch($sformatf("cell_alive %b, expected %b",
                                    result_if.cell_alive, view_seen.alive));
        end
        if (result_if.neighbor_count !== view_seen.count) begin
          report_mismatch($sformatf("neighbor_count %0d, expected %0d",
                                    result_if.neighbor_count, view_seen.count));
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    item_if.valid  = 1'b0;
    item_if.action = lge_pkg::ACT_READ;
    item_if.row    = '0;
    item_if.col    = '0;
    mismatch_count = 0;
    hold_cycles    = 0;
    idle_on        = 1'b1;
    foreach (grid_rows[r]) grid_rows[r] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_corners();
    test_blinker();
    test_border_neighbours();
    test_result_stall();
    test_random_play(70);
    idle_on = 1'b0;
    test_random_play(40);

    repeat (lge_pkg::GRID_ROWS + 40) @(posedge clk_i);
    if (cell_views_due.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", cell_views_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
